### rtl/grpf_pkg.sv
// Package for the relativistic precession force block: payload types, widths and codes.
package grpf_pkg;

   localparam int unsigned POS_W    = 32;
   localparam int unsigned ACC48_W  = 48;
   localparam int unsigned MASS_W   = 32;
   localparam int unsigned INV_W    = 32;
   localparam int unsigned PREF_W   = 48;
   localparam int unsigned MAG_W    = 33;
   localparam int unsigned QUOT_W   = 47;
   localparam int unsigned ALU_W    = 134;
   localparam int unsigned MULB_W   = 66;
   localparam int unsigned CNT_W    = 7;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PREFACTOR = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_MASS  = 1'd1;

   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_PARTICLE = 1'b1;

   localparam logic [ACC48_W-1:0] SAT_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [ACC48_W-1:0] SAT_MIN = 48'h8000_0000_0000;

   // Last step index of each serial multiply and of the division.
   localparam logic [CNT_W-1:0] LAST_SQ  = 7'd32;
   localparam logic [CNT_W-1:0] LAST_R4  = 7'd65;
   localparam logic [CNT_W-1:0] LAST_PM  = 7'd32;
   localparam logic [CNT_W-1:0] LAST_CM  = 7'd31;
   localparam logic [CNT_W-1:0] LAST_DIV = 7'd46;

   typedef struct packed {
      logic                     cmd;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  pos_z;
      logic [MASS_W-1:0]        body_mass;
      logic                     last_body;
   } req_type;

   typedef struct packed {
      logic                      target;
      logic signed [ACC48_W-1:0] dacc_x;
      logic signed [ACC48_W-1:0] dacc_y;
      logic signed [ACC48_W-1:0] dacc_z;
      logic                      end_of_run;
   } rsp_type;

endpackage

### rtl/gr_precession_force.sv
// Top level of the relativistic precession force block with its shared add/subtract unit.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | grpf_pkg::req_type
//  rsp     | out       | rsp_valid / rsp_stall  | grpf_pkg::rsp_type
//  csr     | in        | csr_we, csr_index      | csr_wdata (48 bits)
//
// A particle beat forms every product by shift-and-add and the r^4 division by restoring
// steps, all on one 134-bit adder: r^2, r^4 and per axis P*|d|, divide, mass scaling, a
// set-up step and the accumulate step. A zero or saturating divide is shorter.
// Results leave through one output register; the total follows the particle result.
// Reset is synchronous and clears the central position, the accumulators and the prefactor.
// req_stall is high from acceptance of a particle until its last result has been taken.
module gr_precession_force (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  grpf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output grpf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [grpf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [grpf_pkg::PREF_W-1:0]         csr_wdata
);

   localparam int unsigned AW = grpf_pkg::ALU_W;
   localparam int unsigned BW = grpf_pkg::MULB_W;
   localparam int unsigned CW = grpf_pkg::CNT_W;
   localparam int unsigned DW = grpf_pkg::ACC48_W;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SQ   = 4'd1;
   localparam logic [3:0] ST_R4   = 4'd2;
   localparam logic [3:0] ST_PM   = 4'd3;
   localparam logic [3:0] ST_CHK  = 4'd4;
   localparam logic [3:0] ST_DIV  = 4'd5;
   localparam logic [3:0] ST_CMS  = 4'd6;
   localparam logic [3:0] ST_CM1  = 4'd7;
   localparam logic [3:0] ST_CM2  = 4'd8;
   localparam logic [3:0] ST_ACC  = 4'd9;
   localparam logic [3:0] ST_OUT1 = 4'd10;
   localparam logic [3:0] ST_OUT2 = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    axis_ff, axis_in, axis_nxt;
   logic [AW-1:0] acc_ff, acc_in, a_ff, a_in, r4_ff, r4_in;
   logic [BW-1:0] b_ff, b_in;
   logic [grpf_pkg::QUOT_W-1:0] q_ff, q_in;

   logic [grpf_pkg::POS_W-1:0]  cpos_ff [3];
   logic [grpf_pkg::POS_W-1:0]  cpos_in [3];
   logic [DW-1:0]               cacc_ff [3];
   logic [DW-1:0]               cacc_in [3];
   logic [DW-1:0]               corr_ff [3];
   logic [DW-1:0]               corr_in [3];
   logic [grpf_pkg::MAG_W-1:0]  mag_ff [3];
   logic [grpf_pkg::MAG_W-1:0]  mag_in [3];
   logic [2:0]                  dpos_ff, dpos_in;
   logic [grpf_pkg::MASS_W-1:0] mass_ff, mass_in;
   logic                        last_ff, last_in;
   logic [grpf_pkg::PREF_W-1:0] pref_ff, pref_in;
   logic [grpf_pkg::INV_W-1:0]  inv_ff, inv_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   grpf_pkg::rsp_type           rsp_ff, rsp_in;

   // Shared adder: shift-and-add for products, compare and subtract for the division.
   logic [AW-1:0] alu_x, alu_y;
   logic          alu_sub;
   logic [AW:0]   alu_sum;
   logic [AW-1:0] alu_res;
   logic          alu_geq;

   always_comb begin
      alu_x   = acc_ff;
      alu_y   = b_ff[0] ? a_ff : '0;
      alu_sub = 1'b0;
      case (state_ff)
         ST_DIV: begin
            alu_x   = {acc_ff[AW-2:0], 1'b0};
            alu_y   = r4_ff;
            alu_sub = 1'b1;
         end
         ST_CHK: begin
            alu_y   = r4_ff;
            alu_sub = 1'b1;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   assign alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)}
                    + {{AW{1'b0}}, alu_sub};
   assign alu_res = alu_sum[AW-1:0];
   assign alu_geq = alu_sum[AW];

   // Offsets from the central body for an arriving particle.
   logic [grpf_pkg::MAG_W-1:0] d_new [3];
   logic [grpf_pkg::POS_W-1:0] pos_new [3];
   assign pos_new[0] = req_data.pos_x;
   assign pos_new[1] = req_data.pos_y;
   assign pos_new[2] = req_data.pos_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d_new[k] = {pos_new[k][grpf_pkg::POS_W-1], pos_new[k]}
                    - {cpos_ff[k][grpf_pkg::POS_W-1], cpos_ff[k]};
      end
   end

   logic [grpf_pkg::MAG_W-1:0] mag_sel;
   logic [DW-1:0]              corr_sel, cacc_sel, cmag, contrib;
   logic [grpf_pkg::QUOT_W-1:0] q_fin;
   logic [63:0]                scaled;
   logic                       sc_over, corr_gtz;
   logic [DW:0]                cacc_sum;

   assign axis_nxt = axis_ff + 2'd1;
   assign mag_sel  = mag_ff[axis_nxt];
   assign corr_sel = corr_ff[axis_ff];
   assign cacc_sel = cacc_ff[axis_ff];
   assign cmag     = corr_sel[DW-1] ? (DW'(0) - corr_sel) : corr_sel;
   assign q_fin    = {q_ff[grpf_pkg::QUOT_W-2:0], alu_geq};
   assign scaled   = acc_ff[111:48];
   assign sc_over  = |scaled[63:47];
   assign corr_gtz = !corr_sel[DW-1] && (corr_sel != '0);

   always_comb begin
      if (sc_over) begin
         contrib = corr_gtz ? grpf_pkg::SAT_MIN : grpf_pkg::SAT_MAX;
      end else if (corr_gtz) begin
         contrib = DW'(0) - {1'b0, scaled[46:0]};
      end else begin
         contrib = {1'b0, scaled[46:0]};
      end
   end

   assign cacc_sum = {cacc_sel[DW-1], cacc_sel} + {contrib[DW-1], contrib};

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      axis_in      = axis_ff;
      acc_in       = acc_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      r4_in        = r4_ff;
      q_in         = q_ff;
      cpos_in      = cpos_ff;
      cacc_in      = cacc_ff;
      corr_in      = corr_ff;
      mag_in       = mag_ff;
      dpos_in      = dpos_ff;
      mass_in      = mass_ff;
      last_in      = last_ff;
      pref_in      = pref_ff;
      inv_in       = inv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (csr_we) begin
         case (csr_index)
            grpf_pkg::CSR_PREFACTOR: pref_in = csr_wdata;
            grpf_pkg::CSR_INV_MASS:  inv_in  = csr_wdata[grpf_pkg::INV_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.cmd == grpf_pkg::CMD_LOAD) begin
                  for (int k = 0; k < 3; k++) begin
                     cpos_in[k] = pos_new[k];
                     cacc_in[k] = '0;
                  end
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     mag_in[k]  = d_new[k][grpf_pkg::MAG_W-1] ?
                                  (grpf_pkg::MAG_W'(0) - d_new[k]) : d_new[k];
                     dpos_in[k] = !d_new[k][grpf_pkg::MAG_W-1] && (d_new[k] != '0);
                  end
                  mass_in  = req_data.body_mass;
                  last_in  = req_data.last_body;
                  axis_in  = 2'd0;
                  cnt_in   = '0;
                  acc_in   = '0;
                  a_in     = AW'(mag_in[0]);
                  b_in     = BW'(mag_in[0]);
                  state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            // The accumulator keeps summing the squares of all three axes.
            acc_in = alu_res;
            a_in   = a_ff << 1;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == grpf_pkg::LAST_SQ) begin
               cnt_in = '0;
               if (axis_ff == 2'd2) begin
                  a_in     = alu_res;
                  b_in     = alu_res[BW-1:0];
                  acc_in   = '0;
                  state_in = ST_R4;
               end else begin
                  axis_in = axis_nxt;
                  a_in    = AW'(mag_sel);
                  b_in    = BW'(mag_sel);
               end
            end
         end
         ST_R4: begin
            acc_in = alu_res;
            a_in   = a_ff << 1;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == grpf_pkg::LAST_R4) begin
               r4_in    = alu_res;
               cnt_in   = '0;
               axis_in  = 2'd0;
               acc_in   = '0;
               a_in     = AW'(pref_ff);
               b_in     = BW'(mag_ff[0]);
               state_in = ST_PM;
            end
         end
         ST_PM: begin
            acc_in = alu_res;
            a_in   = a_ff << 1;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == grpf_pkg::LAST_PM) begin
               cnt_in = '0;
               if (r4_ff == '0) begin
                  corr_in[axis_ff] = '0;
                  state_in         = ST_CMS;
               end else begin
                  // The numerator is P*|d|*2^64; its part above bit 46 starts the remainder.
                  acc_in   = alu_res << 17;
                  state_in = ST_CHK;
               end
            end
         end
         ST_CHK: begin
            if (alu_geq) begin
               corr_in[axis_ff] = dpos_ff[axis_ff] ? grpf_pkg::SAT_MIN : grpf_pkg::SAT_MAX;
               state_in         = ST_CMS;
            end else begin
               q_in     = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            acc_in = alu_geq ? alu_res : {acc_ff[AW-2:0], 1'b0};
            q_in   = q_fin;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == grpf_pkg::LAST_DIV) begin
               corr_in[axis_ff] = dpos_ff[axis_ff] ? (DW'(0) - {1'b0, q_fin})
                                                   : {1'b0, q_fin};
               state_in         = ST_CMS;
            end
         end
         ST_CMS: begin
            acc_in   = '0;
            a_in     = AW'(cmag);
            b_in     = BW'(mass_ff);
            cnt_in   = '0;
            state_in = ST_CM1;
         end
         ST_CM1: begin
            acc_in = alu_res;
            a_in   = a_ff << 1;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == grpf_pkg::LAST_CM) begin
               acc_in   = '0;
               a_in     = alu_res;
               b_in     = BW'(inv_ff);
               cnt_in   = '0;
               state_in = ST_CM2;
            end
         end
         ST_CM2: begin
            acc_in = alu_res;
            a_in   = a_ff << 1;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == grpf_pkg::LAST_CM) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            if (cacc_sum[DW] != cacc_sum[DW-1]) begin
               cacc_in[axis_ff] = cacc_sum[DW] ? grpf_pkg::SAT_MIN : grpf_pkg::SAT_MAX;
            end else begin
               cacc_in[axis_ff] = cacc_sum[DW-1:0];
            end
            if (axis_ff == 2'd2) begin
               rsp_in.target     = 1'b0;
               rsp_in.dacc_x     = corr_ff[0];
               rsp_in.dacc_y     = corr_ff[1];
               rsp_in.dacc_z     = corr_in[2];
               rsp_in.end_of_run = 1'b0;
               rsp_valid_in      = 1'b1;
               state_in          = ST_OUT1;
            end else begin
               axis_in  = axis_nxt;
               acc_in   = '0;
               a_in     = AW'(pref_ff);
               b_in     = BW'(mag_sel);
               cnt_in   = '0;
               state_in = ST_PM;
            end
         end
         ST_OUT1: begin
            if (!rsp_stall) begin
               if (last_ff) begin
                  rsp_in.target     = 1'b1;
                  rsp_in.dacc_x     = cacc_ff[0];
                  rsp_in.dacc_y     = cacc_ff[1];
                  rsp_in.dacc_z     = cacc_ff[2];
                  rsp_in.end_of_run = 1'b1;
                  state_in          = ST_OUT2;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_OUT2: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pref_ff      <= '0;
         inv_ff       <= grpf_pkg::INV_W'(65536);
         for (int k = 0; k < 3; k++) begin
            cpos_ff[k] <= '0;
            cacc_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         pref_ff      <= pref_in;
         inv_ff       <= inv_in;
         cpos_ff      <= cpos_in;
         cacc_ff      <= cacc_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      r4_ff   <= r4_in;
      q_ff    <= q_in;
      corr_ff <= corr_in;
      mag_ff  <= mag_in;
      dpos_ff <= dpos_in;
      mass_ff <= mass_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   // A result is only shown from one of the two output states.
   a_valid_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_OUT1 || state_ff == ST_OUT2))
      else $error("result valid outside an output state");

   // The division only runs against a nonzero r^4.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (r4_ff != '0))
      else $error("division started with zero divisor");

   // The central total is only sent after a particle marked as last.
   a_total_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT2) |-> (last_ff && rsp_ff.end_of_run && rsp_ff.target))
      else $error("central total without last particle");

   // The axis index never passes the third axis.
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      (axis_ff != 2'd3))
      else $error("axis index out of range");

endmodule

### tb/tb.sv
// Self-checking testbench for gr_precession_force: random and directed beats against a predictor.
`timescale 1ns / 100ps

module tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 700;
   localparam int LONG_HOLD      = 3000;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   grpf_pkg::req_type              req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   grpf_pkg::rsp_type              rsp_data;
   logic                           csr_we;
   logic [grpf_pkg::CSR_IDX_W-1:0] csr_index;
   logic [grpf_pkg::PREF_W-1:0]    csr_wdata;

   bit no_idle;
   bit long_hold;
   int items_sent;

   gr_precession_force uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   class precession_scoreboard;
      logic [grpf_pkg::PREF_W-1:0] prefactor;
      logic [grpf_pkg::INV_W-1:0]  inv_mass;
      longint                      centre[3];
      longint                      central_acc[3];
      grpf_pkg::rsp_type           expected_q[$];
      int                          errors;

      function new();
         prefactor = '0;
         inv_mass = 32'd65536;
         for (int k = 0; k < 3; k++) begin
            centre[k] = 0;
            central_acc[k] = 0;
         end
         errors = 0;
      endfunction

      function void write_register(logic [grpf_pkg::CSR_IDX_W-1:0] idx,
                                   logic [grpf_pkg::PREF_W-1:0] value);
         if (idx == grpf_pkg::CSR_PREFACTOR) prefactor = value;
         else if (idx == grpf_pkg::CSR_INV_MASS) inv_mass = value[grpf_pkg::INV_W-1:0];
      endfunction

      // Magnitude to signed 48 bits, saturating at the field limits.
      function logic signed [grpf_pkg::ACC48_W-1:0] saturate(bit neg, logic [255:0] magnitude);
         if (neg) return (magnitude >= 256'h8000_0000_0000) ? grpf_pkg::SAT_MIN
                                                            : -magnitude[47:0];
         return (magnitude > 256'h7FFF_FFFF_FFFF) ? grpf_pkg::SAT_MAX : magnitude[47:0];
      endfunction

      function void note_request(grpf_pkg::req_type r);
         longint                              pos[3];
         longint                              offset[3];
         logic [255:0]                        mag[3];
         logic [255:0]                        r2;
         logic [255:0]                        r4;
         logic [255:0]                        quotient;
         logic signed [grpf_pkg::ACC48_W-1:0] corr[3];
         longint                              c;
         longint                              s;
         grpf_pkg::rsp_type                   e;
         pos[0] = longint'($signed(r.pos_x));
         pos[1] = longint'($signed(r.pos_y));
         pos[2] = longint'($signed(r.pos_z));
         if (r.cmd == grpf_pkg::CMD_LOAD) begin
            for (int k = 0; k < 3; k++) begin
               centre[k] = pos[k];
               central_acc[k] = 0;
            end
            return;
         end
         r2 = '0;
         for (int k = 0; k < 3; k++) begin
            offset[k] = pos[k] - centre[k];
            mag[k] = (offset[k] < 0) ? 256'(-offset[k]) : 256'(offset[k]);
            r2 += mag[k] * mag[k];
         end
         r4 = r2 * r2;
         for (int k = 0; k < 3; k++) begin
            if (r4 == 0) corr[k] = '0;
            else begin
               quotient = ((256'(prefactor) * mag[k]) << 64) / r4;
               corr[k] = saturate(offset[k] > 0, quotient);
            end
         end
         // The central body takes the reaction, scaled by the mass ratio.
         for (int k = 0; k < 3; k++) begin
            c = longint'(corr[k]);
            quotient = (256'(c < 0 ? -c : c) * 256'(r.body_mass) * 256'(inv_mass)) >> 48;
            s = central_acc[k] + longint'(saturate(c > 0, quotient));
            if (s > longint'(grpf_pkg::SAT_MAX)) s = longint'(grpf_pkg::SAT_MAX);
            if (s < -longint'(grpf_pkg::SAT_MAX) - 1) s = -longint'(grpf_pkg::SAT_MAX) - 1;
            central_acc[k] = s;
         end
         e.target = 1'b0;
         e.dacc_x = corr[0];
         e.dacc_y = corr[1];
         e.dacc_z = corr[2];
         e.end_of_run = 1'b0;
         expected_q.push_back(e);
         if (r.last_body) begin
            e.target = 1'b1;
            e.dacc_x = central_acc[0][47:0];
            e.dacc_y = central_acc[1][47:0];
            e.dacc_z = central_acc[2][47:0];
            e.end_of_run = 1'b1;
            expected_q.push_back(e);
         end
      endfunction

      function void check_result(grpf_pkg::rsp_type a);
         grpf_pkg::rsp_type e;
         if (expected_q.size() == 0) begin
            $error("result beat with nothing expected: %h", a);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (a.target !== e.target) begin
            $error("target: expected %0d, got %0d", e.target, a.target); errors++;
         end
         if (a.dacc_x !== e.dacc_x) begin
            $error("dacc_x: expected %0d, got %0d", e.dacc_x, a.dacc_x); errors++;
         end
         if (a.dacc_y !== e.dacc_y) begin
            $error("dacc_y: expected %0d, got %0d", e.dacc_y, a.dacc_y); errors++;
         end
         if (a.dacc_z !== e.dacc_z) begin
            $error("dacc_z: expected %0d, got %0d", e.dacc_z, a.dacc_z); errors++;
         end
         if (a.end_of_run !== e.end_of_run) begin
            $error("end_of_run: expected %0d, got %0d", e.end_of_run, a.end_of_run);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   precession_scoreboard board = new();

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Beats are taken from values sampled before this edge's updates land.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_data);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: random back-pressure, with one long hold when asked for.
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 10);
         if (long_hold) begin
            long_hold = 1'b0;
            n = LONG_HOLD;
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_beat(grpf_pkg::req_type r);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      // Wait for an edge first, so the last accepted beat has reached the scoreboard.
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [grpf_pkg::CSR_IDX_W-1:0] idx,
                            logic [grpf_pkg::PREF_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      board.write_register(idx, value);
      @(posedge clock);
   endtask

   function automatic grpf_pkg::req_type make_req(logic cmd, logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z, logic [31:0] mass,
                                                  logic last);
      grpf_pkg::req_type r;
      r.cmd = cmd;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.body_mass = mass;
      r.last_body = last;
      return r;
   endfunction

   // Coordinate near a centre at a random scale, so both tiny and huge radii occur.
   function automatic logic [31:0] near(logic [31:0] centre);
      int shift;
      if ($urandom_range(0, 9) == 0) return $urandom;
      shift = $urandom_range(0, 31);
      return centre + ($signed($urandom) >>> shift);
   endfunction

   task automatic random_set();
      grpf_pkg::req_type r;
      int                count;
      logic [31:0]       cx;
      logic [31:0]       cy;
      logic [31:0]       cz;
      cx = $urandom;
      cy = $urandom;
      cz = $urandom;
      if ($urandom_range(0, 1)) begin
         cx = $signed(cx) >>> $urandom_range(0, 31);
         cy = $signed(cy) >>> $urandom_range(0, 31);
         cz = $signed(cz) >>> $urandom_range(0, 31);
      end
      send_beat(make_req(grpf_pkg::CMD_LOAD, cx, cy, cz, $urandom,
                         1'($urandom_range(0, 1))));
      count = $urandom_range(1, 5);
      for (int i = 0; i < count; i++)
         send_beat(make_req(grpf_pkg::CMD_PARTICLE, near(cx), near(cy), near(cz), $urandom,
                            i == count - 1));
   endtask

   logic [grpf_pkg::PREF_W-1:0] pref_setting;
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = grpf_pkg::CSR_PREFACTOR;
      csr_wdata = '0;
      no_idle = 1'b0;
      long_hold = 1'b0;
      items_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: particle before any load, zero distance, extreme coordinates.
      write_csr(grpf_pkg::CSR_PREFACTOR, 48'h0000_0100_0000);
      write_csr(grpf_pkg::CSR_INV_MASS, 48'h0000_0001_0000);
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_FFFF,
                         1'b0));
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1));
      send_beat(make_req(grpf_pkg::CMD_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                         32'hFFFF_FFFF, 1'b1));
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                         32'h8000_0000, 1'b0));
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0,
                         1'b0));
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'h7FFF_FFFF, 32'h8000_0001, 32'h1, 32'h1,
                         1'b1));
      send_beat(make_req(grpf_pkg::CMD_LOAD, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'h0000_0001, 32'h0, 32'h0, 32'hFFFF_FFFF,
                         1'b0));
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1,
                         32'hFFFF_FFFF, 1'b0));
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'h0, 32'h0, 32'h0, 32'h1234_5678, 1'b1));
      // The accumulator carries over after a total until the next load.
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'h0000_0002, 32'hFFFF_FFFE, 32'h0,
                         32'hFFFF_FFFF, 1'b1));
      drain();
      write_csr(grpf_pkg::CSR_PREFACTOR, '1);
      write_csr(grpf_pkg::CSR_INV_MASS, 48'h0000_FFFF_FFFF);
      send_beat(make_req(grpf_pkg::CMD_LOAD, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'h0000_0001, 32'h0, 32'h0, 32'hFFFF_FFFF,
                         1'b0));
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                         1'b0));
      send_beat(make_req(grpf_pkg::CMD_PARTICLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'hFFFF_FFFF, 1'b1));
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin
               write_csr(grpf_pkg::CSR_PREFACTOR, '0);
               write_csr(grpf_pkg::CSR_INV_MASS, '0);
            end
            1: begin
               write_csr(grpf_pkg::CSR_PREFACTOR, '1);
               write_csr(grpf_pkg::CSR_INV_MASS, 48'h0000_FFFF_FFFF);
            end
            default: begin
               pref_setting = grpf_pkg::PREF_W'({$urandom, $urandom});
               write_csr(grpf_pkg::CSR_PREFACTOR, pref_setting >> $urandom_range(0, 47));
               write_csr(grpf_pkg::CSR_INV_MASS,
                         grpf_pkg::PREF_W'($urandom >> $urandom_range(0, 31)));
            end
         endcase
         no_idle = (phase == 4);
         // With the receiver held, the block fills and has to stall the sender.
         if (phase == 2) long_hold = 1'b1;
         while (items_sent < 20 + (phase + 1) * 150) begin
            if ($urandom_range(0, 4) != 0) random_set();
            else send_beat(make_req(1'($urandom_range(0, 1)), near(0), near(0), near(0),
                                    $urandom, 1'($urandom_range(0, 1))));
         end
         drain();
      end

      if (board.errors == 0 && board.pending() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### files.f
rtl/grpf_pkg.sv
rtl/gr_precession_force.sv
tb/tb.sv
